// ----- rtl/sac_pkg.sv -----
// shared constants, types and register codes of the set-associative cache tag block
package sac_pkg;

    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;
    localparam int ADDR_BITS    = 32;

    // fixed field widths
    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 32;
    localparam int CNT_W      = 32;
    localparam int OUT_SET_W  = 6;
    localparam int SIB_W      = 3;
    localparam int WAYS_CFG_W = 4;
    localparam int BOB_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // derived geometry
    localparam int NUM_SETS  = 1 << MAX_SET_BITS;
    localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int SB_W      = $clog2(MAX_SET_BITS + 1) > 0 ? $clog2(MAX_SET_BITS + 1) : 1;
    localparam int WAY_IDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);
    localparam int SHAMT_W   = $clog2(ADDR_W + MAX_SET_BITS + 1);

    localparam logic [ADDR_W-1:0] ADDR_MASK =
        (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OFFSET_BITS = 2'd2;

    // access kinds
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_STORE = 1'b1;

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [TAG_W-1:0] tag;
    } way_t;

    // position 0 is most recently used
    typedef way_t [MAX_WAYS-1:0] row_t;

    localparam int ROW_W = $bits(row_t);

    typedef struct packed {
        logic             hit;
        logic             wrote_back;
        logic [TAG_W-1:0] victim_tag;
    } lookup_t;

endpackage

// ----- rtl/sac_if.sv -----
// request and response channel interfaces of the cache tag block
interface sac_req_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [sac_pkg::ADDR_W-1:0] address;

    modport source (output valid, output mode, output address, input ready);
    modport sink (input valid, input mode, input address, output ready);
endinterface

interface sac_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic                          wrote_back;
    logic [sac_pkg::TAG_W-1:0]     victim_tag;
    logic [sac_pkg::OUT_SET_W-1:0] victim_set;
    logic [sac_pkg::CNT_W-1:0]     load_hits;
    logic [sac_pkg::CNT_W-1:0]     load_misses;
    logic [sac_pkg::CNT_W-1:0]     store_hits;
    logic [sac_pkg::CNT_W-1:0]     store_misses;
    logic [sac_pkg::CNT_W-1:0]     total_accesses;

    modport source (output valid, output hit, output wrote_back, output victim_tag,
                    output victim_set, output load_hits, output load_misses,
                    output store_hits, output store_misses, output total_accesses,
                    input ready);
    modport sink (input valid, input hit, input wrote_back, input victim_tag,
                  input victim_set, input load_hits, input load_misses,
                  input store_hits, input store_misses, input total_accesses,
                  output ready);
endinterface

// ----- rtl/sac_ram.sv -----
// generic single-write, single-read ram with registered read data
module sac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                            clk,
    input  logic                            we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                wdata,
    input  logic                            re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/sac_set_update.sv -----
// lookup of one set row and its lru reorder, dirty marking and victim report
module sac_set_update (
    input  sac_pkg::row_t                         row_in,
    input  logic [sac_pkg::TAG_W-1:0]             tag,
    input  logic [sac_pkg::WAY_CNT_W-1:0]         ways,
    input  logic                                  store,
    output sac_pkg::row_t                         row_out,
    output sac_pkg::lookup_t                      res
);

    logic [sac_pkg::MAX_WAYS-1:0]  match;
    logic                          hit;
    logic [sac_pkg::WAY_IDX_W-1:0] hit_pos;
    logic [sac_pkg::WAY_IDX_W-1:0] last;
    logic [sac_pkg::WAY_IDX_W-1:0] pos;
    sac_pkg::way_t                 front;
    sac_pkg::way_t                 last_way;

    always_comb
    begin
        for (int i = 0; i < sac_pkg::MAX_WAYS; i++)
        begin
            match[i] = (sac_pkg::WAY_CNT_W'(i) < ways) && row_in[i].valid
                       && (row_in[i].tag == tag);
        end

        // lowest matching position wins
        hit     = 1'b0;
        hit_pos = '0;
        for (int i = sac_pkg::MAX_WAYS - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit     = 1'b1;
                hit_pos = sac_pkg::WAY_IDX_W'(i);
            end
        end

        last     = sac_pkg::WAY_IDX_W'(ways - sac_pkg::WAY_CNT_W'(1));
        last_way = row_in[last];
        pos      = hit ? hit_pos : last;

        if (hit)
        begin
            front = row_in[hit_pos];
        end
        else
        begin
            front.valid = 1'b1;
            front.dirty = 1'b0;
            front.tag   = tag;
        end
        if (store)
        begin
            front.dirty = 1'b1;
        end

        // positions up to pos slide down one, the rest stay put
        row_out[0] = front;
        for (int i = 1; i < sac_pkg::MAX_WAYS; i++)
        begin
            row_out[i] = (sac_pkg::WAY_IDX_W'(i) <= pos) ? row_in[i-1] : row_in[i];
        end

        res.hit        = hit;
        res.wrote_back = !hit && last_way.valid && last_way.dirty;
        res.victim_tag = res.wrote_back ? last_way.tag : '0;
    end

endmodule

// ----- rtl/set_assoc_lru_writeback_cache_top.sv -----
// Tag-only set-associative cache with LRU replacement, write-back and write-allocate.
// Each request beat is a load or store address; each response beat reports hit, a
// dirty victim (tag and set) and the five running access counters after the access.
// One access is taken every cycle when the response side keeps up; a request beat is
// registered in the lookup stage, its result in the response register. Throughput is
// set by the set-row ram, which holds a whole set (all ways with valid, dirty and tag)
// in one word and is read and written once per access; a forwarding register covers
// back-to-back accesses to the same set. A per-set flag reset to zero makes never
// written sets read as empty, so no clearing pass is needed after reset. Configuration
// registers may be written only while no access is in flight.
module set_assoc_lru_writeback_cache_top (
    input  logic                            clk,
    input  logic                            rst_n,
    sac_req_if.sink                         req,
    sac_rsp_if.source                       rsp,
    input  logic                            cfg_we,
    input  logic [sac_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sac_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    // configuration
    logic [sac_pkg::SIB_W-1:0]      sib_reg;
    logic [sac_pkg::WAYS_CFG_W-1:0] ways_cfg_reg;
    logic [sac_pkg::BOB_W-1:0]      bob_reg;

    // lookup stage
    logic                        s1_vld_reg;
    logic                        s1_vld_next;
    logic                        s1_store_reg;
    logic [sac_pkg::TAG_W-1:0]   s1_tag_reg;
    logic [sac_pkg::SET_W-1:0]   s1_set_reg;

    // forwarding of the row written at the edge the current row was read
    logic                        fwd_vld_reg;
    logic [sac_pkg::SET_W-1:0]   fwd_set_reg;
    sac_pkg::row_t               fwd_row_reg;

    logic [sac_pkg::NUM_SETS-1:0] row_init_reg;

    // result register
    logic                        out_vld_reg;
    logic                        out_vld_next;
    logic                        out_hit_reg;
    logic                        out_wb_reg;
    logic [sac_pkg::TAG_W-1:0]   out_vtag_reg;
    logic [sac_pkg::SET_W-1:0]   out_set_reg;

    logic [sac_pkg::CNT_W-1:0]   cnt_lh_reg;
    logic [sac_pkg::CNT_W-1:0]   cnt_lm_reg;
    logic [sac_pkg::CNT_W-1:0]   cnt_sh_reg;
    logic [sac_pkg::CNT_W-1:0]   cnt_sm_reg;
    logic [sac_pkg::CNT_W-1:0]   cnt_total_reg;

    logic                        accept;
    logic                        s1_adv;
    logic [sac_pkg::SB_W-1:0]    sb;
    logic [sac_pkg::SHAMT_W-1:0] tag_shamt;
    logic [sac_pkg::ADDR_W-1:0]  addr;
    logic [sac_pkg::SET_W-1:0]   set_mask;
    logic [sac_pkg::SET_W-1:0]   in_set;
    logic [sac_pkg::TAG_W-1:0]   in_tag;
    logic [sac_pkg::WAY_CNT_W-1:0] ways;

    logic [sac_pkg::ROW_W-1:0]   ram_rdata;
    sac_pkg::row_t               row_cur;
    sac_pkg::row_t               row_new;
    sac_pkg::lookup_t            lkp;

    // handshake
    assign s1_adv    = s1_vld_reg && (!out_vld_reg || rsp.ready);
    assign req.ready = !s1_vld_reg || s1_adv;
    assign accept    = req.valid && req.ready;

    // address split
    always_comb
    begin
        sb = (32'(sib_reg) > sac_pkg::MAX_SET_BITS) ? sac_pkg::SB_W'(sac_pkg::MAX_SET_BITS)
                                                     : sac_pkg::SB_W'(sib_reg);
        addr      = req.address & sac_pkg::ADDR_MASK;
        set_mask  = ~({sac_pkg::SET_W{1'b1}} << sb);
        in_set    = sac_pkg::SET_W'(addr >> bob_reg) & set_mask;
        tag_shamt = sac_pkg::SHAMT_W'(bob_reg) + sac_pkg::SHAMT_W'(sb);
        in_tag    = sac_pkg::TAG_W'(addr >> tag_shamt);
    end

    always_comb
    begin
        if (ways_cfg_reg == '0)
        begin
            ways = sac_pkg::WAY_CNT_W'(1);
        end
        else if (32'(ways_cfg_reg) > sac_pkg::MAX_WAYS)
        begin
            ways = sac_pkg::WAY_CNT_W'(sac_pkg::MAX_WAYS);
        end
        else
        begin
            ways = sac_pkg::WAY_CNT_W'(ways_cfg_reg);
        end
    end

    sac_ram #(
        .WIDTH (sac_pkg::ROW_W),
        .DEPTH (sac_pkg::NUM_SETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_set_reg),
        .wdata (row_new),
        .re    (accept),
        .raddr (in_set),
        .rdata (ram_rdata)
    );

    // current row: forwarded or from ram, empty if the set was never written
    always_comb
    begin
        if (fwd_vld_reg && (fwd_set_reg == s1_set_reg))
        begin
            row_cur = fwd_row_reg;
        end
        else
        begin
            row_cur = sac_pkg::row_t'(ram_rdata);
        end
        if (!row_init_reg[s1_set_reg])
        begin
            for (int i = 0; i < sac_pkg::MAX_WAYS; i++)
            begin
                row_cur[i].valid = 1'b0;
                row_cur[i].dirty = 1'b0;
            end
        end
    end

    sac_set_update u_set_update (
        .row_in  (row_cur),
        .tag     (s1_tag_reg),
        .ways    (ways),
        .store   (s1_store_reg),
        .row_out (row_new),
        .res     (lkp)
    );

    always_comb
    begin
        priority if (accept)
        begin
            s1_vld_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_vld_next = 1'b0;
        end
        else
        begin
            s1_vld_next = s1_vld_reg;
        end

        priority if (s1_adv)
        begin
            out_vld_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sib_reg       <= '0;
            ways_cfg_reg  <= sac_pkg::WAYS_CFG_W'(1);
            bob_reg       <= '0;
            s1_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
            fwd_vld_reg   <= 1'b0;
            row_init_reg  <= '0;
            cnt_lh_reg    <= '0;
            cnt_lm_reg    <= '0;
            cnt_sh_reg    <= '0;
            cnt_sm_reg    <= '0;
            cnt_total_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == sac_pkg::CFG_SET_INDEX_BITS)
                begin
                    sib_reg <= sac_pkg::SIB_W'(cfg_wdata);
                end
                if (cfg_index == sac_pkg::CFG_WAYS_IN_USE)
                begin
                    ways_cfg_reg <= sac_pkg::WAYS_CFG_W'(cfg_wdata);
                end
                if (cfg_index == sac_pkg::CFG_BLOCK_OFFSET_BITS)
                begin
                    bob_reg <= sac_pkg::BOB_W'(cfg_wdata);
                end
            end

            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;

            // the new beat's read races this edge's write only if both happen now
            if (accept)
            begin
                fwd_vld_reg <= s1_adv;
            end

            if (s1_adv)
            begin
                row_init_reg[s1_set_reg] <= 1'b1;
                cnt_total_reg            <= cnt_total_reg + 1'b1;
                unique case ({s1_store_reg, lkp.hit})
                    {sac_pkg::MODE_LOAD, 1'b1}:  cnt_lh_reg <= cnt_lh_reg + 1'b1;
                    {sac_pkg::MODE_LOAD, 1'b0}:  cnt_lm_reg <= cnt_lm_reg + 1'b1;
                    {sac_pkg::MODE_STORE, 1'b1}: cnt_sh_reg <= cnt_sh_reg + 1'b1;
                    default:                     cnt_sm_reg <= cnt_sm_reg + 1'b1;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_store_reg <= req.mode;
            s1_tag_reg   <= in_tag;
            s1_set_reg   <= in_set;
        end
        if (s1_adv)
        begin
            fwd_set_reg  <= s1_set_reg;
            fwd_row_reg  <= row_new;
            out_hit_reg  <= lkp.hit;
            out_wb_reg   <= lkp.wrote_back;
            out_vtag_reg <= lkp.victim_tag;
            out_set_reg  <= s1_set_reg;
        end
    end

    // counters change only when a result loads, so they are the result's values
    assign rsp.valid          = out_vld_reg;
    assign rsp.hit            = out_hit_reg;
    assign rsp.wrote_back     = out_wb_reg;
    assign rsp.victim_tag     = out_vtag_reg;
    assign rsp.victim_set     = sac_pkg::OUT_SET_W'(out_set_reg);
    assign rsp.load_hits      = cnt_lh_reg;
    assign rsp.load_misses    = cnt_lm_reg;
    assign rsp.store_hits     = cnt_sh_reg;
    assign rsp.store_misses   = cnt_sm_reg;
    assign rsp.total_accesses = cnt_total_reg;

`ifndef SYNTH
    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> (cnt_total_reg == $past(cnt_total_reg) + 1'b1))
        else $error("total counter did not step with a result");

    a_cnt_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_lh_reg + cnt_lm_reg + cnt_sh_reg + cnt_sm_reg) == cnt_total_reg)
        else $error("hit and miss counters disagree with total");

    a_wb_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_wb_reg) |-> !out_hit_reg)
        else $error("write-back reported on a hit");

    a_row_init: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> row_init_reg[$past(s1_set_reg)])
        else $error("written set not marked initialized");
`endif

endmodule

// ----- bench/set_assoc_lru_writeback_cache_top_tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for the lru write-back cache tag block: shadow cache, random traffic
module set_assoc_lru_writeback_cache_top_tb;

    typedef struct packed {
        logic                       mode;
        logic [sac_pkg::ADDR_W-1:0] address;
    } access_t;

    typedef struct packed {
        logic                          hit;
        logic                          wrote_back;
        logic [sac_pkg::TAG_W-1:0]     victim_tag;
        logic [sac_pkg::OUT_SET_W-1:0] victim_set;
        logic [sac_pkg::CNT_W-1:0]     load_hits;
        logic [sac_pkg::CNT_W-1:0]     load_misses;
        logic [sac_pkg::CNT_W-1:0]     store_hits;
        logic [sac_pkg::CNT_W-1:0]     store_misses;
        logic [sac_pkg::CNT_W-1:0]     total_accesses;
    } outcome_t;

    localparam logic [sac_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [sac_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [sac_pkg::CFG_DATA_W-1:0] cfg_wdata;

    sac_req_if req ();
    sac_rsp_if rsp ();

    set_assoc_lru_writeback_cache_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // shadow copy of the tag store, geometry and counters
    sac_pkg::row_t                  shadow_rows [sac_pkg::NUM_SETS];
    logic [sac_pkg::SIB_W-1:0]      shadow_set_bits;
    logic [sac_pkg::WAYS_CFG_W-1:0] shadow_ways;
    logic [sac_pkg::BOB_W-1:0]      shadow_offset_bits;
    logic [sac_pkg::CNT_W-1:0]      n_load_hit;
    logic [sac_pkg::CNT_W-1:0]      n_load_miss;
    logic [sac_pkg::CNT_W-1:0]      n_store_hit;
    logic [sac_pkg::CNT_W-1:0]      n_store_miss;
    logic [sac_pkg::CNT_W-1:0]      n_total;

    access_t  pending_accesses [$];
    outcome_t expected_outcomes [$];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatches = 0;
    int results_seen = 0;
    int hits_seen = 0;
    int writebacks_seen = 0;
    int quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned active_set_bits();
        return (shadow_set_bits > sac_pkg::MAX_SET_BITS) ? sac_pkg::MAX_SET_BITS
                                                         : shadow_set_bits;
    endfunction

    function automatic int unsigned active_ways();
        if (shadow_ways == 0)
            return 1;
        return (shadow_ways > sac_pkg::MAX_WAYS) ? sac_pkg::MAX_WAYS : shadow_ways;
    endfunction

    // lookup, lru update and counter update for one access
    function automatic outcome_t lookup_and_update(access_t acc);
        outcome_t                  res;
        logic [63:0]               wide_addr;
        logic [sac_pkg::TAG_W-1:0] tag;
        int unsigned               sb;
        int unsigned               nways;
        int unsigned               set_idx;
        int unsigned               pos;
        sac_pkg::way_t             moved;
        res = '0;
        sb = active_set_bits();
        nways = active_ways();
        wide_addr = 64'(acc.address & sac_pkg::ADDR_MASK);
        set_idx = int'((wide_addr >> shadow_offset_bits) & ((64'd1 << sb) - 64'd1));
        tag = sac_pkg::TAG_W'(wide_addr >> (int'(shadow_offset_bits) + sb));
        pos = nways;
        for (int i = 0; i < nways; i++)
        begin
            if (pos == nways && shadow_rows[set_idx][i].valid
                && shadow_rows[set_idx][i].tag == tag)
                pos = i;
        end
        if (pos < nways)
        begin
            res.hit = 1'b1;
        end
        else
        begin
            pos = nways - 1;
            if (shadow_rows[set_idx][pos].valid && shadow_rows[set_idx][pos].dirty)
            begin
                res.wrote_back = 1'b1;
                res.victim_tag = shadow_rows[set_idx][pos].tag;
            end
            shadow_rows[set_idx][pos].valid = 1'b1;
            shadow_rows[set_idx][pos].dirty = 1'b0;
            shadow_rows[set_idx][pos].tag = tag;
        end
        moved = shadow_rows[set_idx][pos];
        for (int i = pos; i > 0; i--)
            shadow_rows[set_idx][i] = shadow_rows[set_idx][i-1];
        shadow_rows[set_idx][0] = moved;
        n_total++;
        if (acc.mode == sac_pkg::MODE_STORE)
        begin
            if (res.hit)
                n_store_hit++;
            else
                n_store_miss++;
            shadow_rows[set_idx][0].dirty = 1'b1;
        end
        else
        begin
            if (res.hit)
                n_load_hit++;
            else
                n_load_miss++;
        end
        res.victim_set = sac_pkg::OUT_SET_W'(set_idx);
        res.load_hits = n_load_hit;
        res.load_misses = n_load_miss;
        res.store_hits = n_store_hit;
        res.store_misses = n_store_miss;
        res.total_accesses = n_total;
        return res;
    endfunction

    // mostly a few tags per set so lines get hit, aged out and written back
    function automatic logic [sac_pkg::ADDR_W-1:0] pick_address();
        int unsigned sb;
        int unsigned nsets;
        int unsigned set_idx;
        logic [63:0] tag;
        logic [63:0] offset_mask;
        logic [63:0] composed;
        sb = active_set_bits();
        nsets = 1 << sb;
        if ($urandom_range(7) == 0)
            return sac_pkg::ADDR_W'($urandom());
        if ($urandom_range(3) == 0)
            tag = 64'($urandom());
        else
            tag = 64'($urandom_range(active_ways() + 2));
        if ($urandom_range(1) == 1)
            set_idx = $urandom_range(nsets > 4 ? 3 : nsets - 1);
        else
            set_idx = $urandom_range(nsets - 1);
        offset_mask = (64'd1 << shadow_offset_bits) - 64'd1;
        composed = (tag << (int'(shadow_offset_bits) + sb))
                 | (64'(set_idx) << shadow_offset_bits)
                 | (64'($urandom()) & offset_mask);
        return composed[sac_pkg::ADDR_W-1:0];
    endfunction

    task automatic queue_access(logic mode, logic [sac_pkg::ADDR_W-1:0] address);
        access_t acc;
        acc.mode = mode;
        acc.address = address;
        pending_accesses.push_back(acc);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_accesses.size() != 0 || req.valid || expected_outcomes.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(logic [sac_pkg::CFG_IDX_W-1:0] idx,
                                  logic [sac_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        unique case (idx)
            sac_pkg::CFG_SET_INDEX_BITS:
                shadow_set_bits = data[sac_pkg::SIB_W-1:0];
            sac_pkg::CFG_WAYS_IN_USE:
                shadow_ways = data[sac_pkg::WAYS_CFG_W-1:0];
            sac_pkg::CFG_BLOCK_OFFSET_BITS:
                shadow_offset_bits = data[sac_pkg::BOB_W-1:0];
            default: ;
        endcase
    endtask

    // drain, change the cache geometry, then queue a batch of random accesses
    task automatic run_phase(int count, logic [sac_pkg::CFG_DATA_W-1:0] set_bits,
                             logic [sac_pkg::CFG_DATA_W-1:0] ways,
                             logic [sac_pkg::CFG_DATA_W-1:0] offset_bits,
                             int send_pct, int stall_pct);
        access_t acc;
        wait_idle();
        write_register(sac_pkg::CFG_SET_INDEX_BITS, set_bits);
        write_register(sac_pkg::CFG_WAYS_IN_USE, ways);
        write_register(sac_pkg::CFG_BLOCK_OFFSET_BITS, offset_bits);
        write_register(CFG_UNMAPPED, sac_pkg::CFG_DATA_W'($urandom()));
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
        begin
            acc.mode = $urandom_range(1) ? sac_pkg::MODE_STORE : sac_pkg::MODE_LOAD;
            acc.address = pick_address();
            pending_accesses.push_back(acc);
        end
    endtask

    // request driver: prediction is taken at the accepted beat
    always @(posedge clk)
    begin : drive_req
        access_t nxt;
        logic    send;
        if (!rst_n)
        begin
            req.valid <= 1'b0;
        end
        else
        begin
            if (req.valid && req.ready)
                expected_outcomes.push_back(lookup_and_update({req.mode, req.address}));
            if (!req.valid || req.ready)
            begin
                send = pending_accesses.size() != 0 && $urandom_range(99) >= send_idle_pct;
                if (send)
                begin
                    nxt = pending_accesses.pop_front();
                    req.mode    <= nxt.mode;
                    req.address <= nxt.address;
                end
                else
                begin
                    req.mode    <= $urandom_range(1) ? sac_pkg::MODE_STORE
                                                     : sac_pkg::MODE_LOAD;
                    req.address <= $urandom();
                end
                req.valid <= send;
            end
        end
    end

    // response monitor and scoreboard
    always @(posedge clk)
    begin : check_rsp
        outcome_t got;
        outcome_t want;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got = {rsp.hit, rsp.wrote_back, rsp.victim_tag, rsp.victim_set,
                       rsp.load_hits, rsp.load_misses, rsp.store_hits, rsp.store_misses,
                       rsp.total_accesses};
                results_seen++;
                hits_seen += got.hit;
                writebacks_seen += got.wrote_back;
                if (expected_outcomes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result beat %0d arrived with nothing expected", results_seen);
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (got.hit !== want.hit || got.wrote_back !== want.wrote_back
                        || got.victim_tag !== want.victim_tag
                        || got.victim_set !== want.victim_set
                        || got.load_hits !== want.load_hits
                        || got.load_misses !== want.load_misses
                        || got.store_hits !== want.store_hits
                        || got.store_misses !== want.store_misses
                        || got.total_accesses !== want.total_accesses)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("result beat %0d differs (expected / actual):",
                                     results_seen);
                            $display("  hit %b/%b wb %b/%b vtag %h/%h set %0d/%0d",
                                     want.hit, got.hit, want.wrote_back, got.wrote_back,
                                     want.victim_tag, got.victim_tag,
                                     want.victim_set, got.victim_set);
                            $display("  lh %0d/%0d lm %0d/%0d sh %0d/%0d sm %0d/%0d tot %0d/%0d",
                                     want.load_hits, got.load_hits,
                                     want.load_misses, got.load_misses,
                                     want.store_hits, got.store_hits,
                                     want.store_misses, got.store_misses,
                                     want.total_accesses, got.total_accesses);
                        end
                    end
                end
            end
            rsp.ready <= $urandom_range(99) >= recv_stall_pct;
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no beat on either channel for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = sac_pkg::CFG_SET_INDEX_BITS;
        cfg_wdata = '0;
        req.valid = 1'b0;
        req.mode = sac_pkg::MODE_LOAD;
        req.address = '0;
        rsp.ready = 1'b0;
        for (int s = 0; s < sac_pkg::NUM_SETS; s++)
            shadow_rows[s] = '0;
        shadow_set_bits = '0;
        shadow_ways = sac_pkg::WAYS_CFG_W'(1);
        shadow_offset_bits = '0;
        n_load_hit = '0;
        n_load_miss = '0;
        n_store_hit = '0;
        n_store_miss = '0;
        n_total = '0;
        send_idle_pct = 32;
        recv_stall_pct = 88;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry: one set, one way, whole address is the tag
        @(negedge clk);
        queue_access(sac_pkg::MODE_LOAD, 32'h0000_0000);
        queue_access(sac_pkg::MODE_STORE, 32'hFFFF_FFFF);
        queue_access(sac_pkg::MODE_LOAD, 32'h0000_0000);
        queue_access(sac_pkg::MODE_LOAD, 32'h0000_0000);
        queue_access(sac_pkg::MODE_STORE, 32'h0000_0000);
        queue_access(sac_pkg::MODE_STORE, 32'h8000_0000);
        queue_access(sac_pkg::MODE_LOAD, 32'h7FFF_FFFF);
        queue_access(sac_pkg::MODE_STORE, 32'h0000_0001);
        queue_access(sac_pkg::MODE_STORE, 32'h0000_0001);
        queue_access(sac_pkg::MODE_LOAD, 32'h0000_0002);

        // eight ways: fill set 0 with dirty lines, then age out the oldest
        run_phase(0, 5'd3, 5'd8, 5'd0, 32, 88);
        @(negedge clk);
        for (int t = 1; t <= 9; t++)
            queue_access(sac_pkg::MODE_STORE, sac_pkg::ADDR_W'(t << 3));
        queue_access(sac_pkg::MODE_LOAD, sac_pkg::ADDR_W'(2 << 3));
        queue_access(sac_pkg::MODE_LOAD, sac_pkg::ADDR_W'(10 << 3));

        run_phase(170, 5'd2, 5'd4, 5'd4, 32, 88);
        // set bits and ways out of range saturate / clamp
        run_phase(100, 5'd7, 5'd0, 5'd0, 32, 88);
        run_phase(60, 5'd6, 5'h1F, 5'd31, 88, 32);
        run_phase(150, 5'd1, 5'd3, 5'd2, 88, 32);
        run_phase(60, 5'd0, 5'd2, 5'd30, 0, 0);
        run_phase(200, 5'd6, 5'd8, 5'd16, 0, 0);
        run_phase(180, 5'd3, 5'd5, 5'd0, 0, 0);
        wait_idle();

        $display("checked %0d accesses across nine geometries (1 to 8 ways, up to 64 sets,",
                 results_seen);
        $display("offsets up to 31 bits): %0d hits, %0d dirty write-backs",
                 hits_seen, writebacks_seen);
        if (mismatches == 0 && expected_outcomes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- set_assoc_lru_writeback_cache_top.f -----
rtl/sac_pkg.sv
rtl/sac_if.sv
rtl/sac_ram.sv
rtl/sac_set_update.sv
rtl/set_assoc_lru_writeback_cache_top.sv
bench/set_assoc_lru_writeback_cache_top_tb.sv
